@@ rtl/gsa_pkg.sv @@
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types and constants for the group slot allocator: pool geometry,
// request kinds, status codes and the payload structs of both channels.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int MAX_GROUPS  = 1024;
  localparam int GROUP_SLOTS = 8;

  localparam int GRP_W  = $clog2(MAX_GROUPS);
  localparam int CNT_W  = $clog2(MAX_GROUPS + 1);
  localparam int OFS_W  = $clog2(GROUP_SLOTS);
  localparam int SLOT_W = 13;

  typedef enum logic [2:0] {
    KIND_ALLOC   = 3'd0,
    KIND_RELEASE = 3'd1,
    KIND_REWIND  = 3'd2,
    KIND_CLEAR   = 3'd3,
    KIND_QUERY   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot_index;
  } gsa_in_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  granted_slot;
    logic               slot_live;
    logic [10:0]        live_groups;
    logic [10:0]        peak_groups;
  } gsa_out_t;

  // Command from the request logic to the free stack.
  typedef struct packed {
    logic              push;
    logic              pop;
    logic              clear;
    logic [GRP_W-1:0]  push_group;
  } stk_cmd_t;

  // Registered view of the free stack.
  typedef struct packed {
    logic [CNT_W-1:0]  depth;
    logic [GRP_W-1:0]  top;
    logic [GRP_W-1:0]  below;
  } stk_stat_t;

endpackage

@@ rtl/gsa_free_stack.sv @@
// ----------------------------------------------------------------------------
// gsa_free_stack
// LIFO of released group numbers. The top entry lives in a register and the
// entry under it is read from the memory every cycle, so pops can follow each
// other back to back.
// ----------------------------------------------------------------------------
module gsa_free_stack (
  input  logic              clk,
  input  logic              rst_n,
  input  gsa_pkg::stk_cmd_t cmd_i,
  output gsa_pkg::stk_stat_t stat_o
);
  import gsa_pkg::*;

  logic [GRP_W-1:0] mem [MAX_GROUPS];

  logic [CNT_W-1:0] depth_r, depth_nxt;
  logic [GRP_W-1:0] top_r, top_nxt;
  logic [GRP_W-1:0] below_r;
  logic [CNT_W-1:0] rd_ptr;

  always_comb begin
    depth_nxt = depth_r;
    top_nxt   = top_r;
    if (cmd_i.clear) begin
      depth_nxt = '0;
    end else if (cmd_i.push) begin
      depth_nxt = depth_r + CNT_W'(1);
      top_nxt   = cmd_i.push_group;
    end else if (cmd_i.pop) begin
      depth_nxt = depth_r - CNT_W'(1);
      top_nxt   = below_r;
    end
  end

  // The entry under the next top; never the slot being pushed this cycle.
  assign rd_ptr = depth_nxt - CNT_W'(2);

  always_ff @(posedge clk) begin
    if (cmd_i.push && !cmd_i.clear) begin
      mem[depth_r[GRP_W-1:0]] <= cmd_i.push_group;
    end
    below_r <= mem[rd_ptr[GRP_W-1:0]];
    top_r   <= top_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  assign stat_o.depth = depth_r;
  assign stat_o.top   = top_r;
  assign stat_o.below = below_r;

endmodule

@@ rtl/group_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// group_slot_allocator
// Allocator of fixed-size slot groups with a LIFO free list and a bump
// pointer, plus release checking and live-slot queries.
// ----------------------------------------------------------------------------
// Usage: a request (kind, slot_index) transfers on the input channel when
// in_valid is high and in_stall is low. Every request produces exactly one
// result on the output channel, in request order: status, granted first slot,
// query answer, and the live and peak group counts after the request.
// From input transfer, the request is held in the request register, while
// the allocation-mark memory is read, and then sits in the result register,
// which drives out_valid. Throughput is one request per cycle while
// out_stall is low; the only state kept between requests (stack top,
// counters, bump pointer) updates in one step.
// The entry below the stack top is prefetched every cycle and the mark of the
// request's group is read on transfer, with the last mark write forwarded.
// Reset empties the free stack and clears the bump pointer, counts and peak;
// no memory sweep is needed because marks above the bump pointer are never
// trusted and stack entries are only read below the depth.
// When out_stall holds the result register, the request register still
// drains into it once free; in_stall rises only when both are occupied.
// ----------------------------------------------------------------------------
module group_slot_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gsa_pkg::gsa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gsa_pkg::gsa_out_t out_data
);
  import gsa_pkg::*;

  // Request register.
  logic     req_v_r, req_v_nxt;
  gsa_in_t  req_r;

  // Result register.
  logic     out_v_r, out_v_nxt;
  gsa_out_t out_r, out_nxt;

  logic accept;
  logic advance;

  // Allocator state.
  logic [CNT_W-1:0] bump_r, bump_nxt;
  logic [CNT_W-1:0] peak_r, peak_nxt;
  logic [CNT_W-1:0] live_r, live_nxt;

  // Allocation marks: one bit per group, only meaningful below bump_r.
  logic             marks [MAX_GROUPS];
  logic             mark_rd_r;
  logic             fwd_v_r;
  logic [GRP_W-1:0] fwd_addr_r;
  logic             fwd_data_r;

  logic             mark_we;
  logic [GRP_W-1:0] mark_addr;
  logic             mark_data;

  stk_cmd_t  stk_cmd;
  stk_stat_t stk_stat;

  logic [GRP_W-1:0] req_group;
  logic             aligned;
  logic             mark_now;
  logic             live_hit;
  logic [GRP_W-1:0] grant_group;

  // Handshake: the request register empties whenever the result register
  // can take a new value.
  assign advance  = req_v_r && (!out_v_r || !out_stall);
  assign in_stall = req_v_r && !advance;
  assign accept   = in_valid && !in_stall;

  assign req_group = req_r.slot_index[SLOT_W-1:OFS_W];
  assign aligned   = (req_r.slot_index[OFS_W-1:0] == '0);

  // A mark written in the same cycle as the read did not reach the read data.
  assign mark_now = (fwd_v_r && (fwd_addr_r == req_group)) ? fwd_data_r : mark_rd_r;
  assign live_hit = ({1'b0, req_group} < bump_r) && mark_now;

  always_comb begin
    bump_nxt    = bump_r;
    peak_nxt    = peak_r;
    live_nxt    = live_r;
    mark_we     = 1'b0;
    mark_addr   = req_group;
    mark_data   = 1'b0;
    grant_group = '0;
    stk_cmd     = '0;
    out_nxt     = out_r;

    if (advance) begin
      out_nxt.status       = ST_OK;
      out_nxt.granted_slot = '0;
      out_nxt.slot_live    = 1'b0;

      unique case (req_r.kind)
        KIND_ALLOC: begin
          if (stk_stat.depth != '0) begin
            grant_group = stk_stat.top;
            stk_cmd.pop = 1'b1;
          end else if (bump_r < CNT_W'(MAX_GROUPS)) begin
            grant_group = bump_r[GRP_W-1:0];
            bump_nxt    = bump_r + CNT_W'(1);
            if (bump_nxt > peak_r) begin
              peak_nxt = bump_nxt;
            end
          end else begin
            out_nxt.status = ST_FULL;
          end
          if (out_nxt.status == ST_OK) begin
            mark_we              = 1'b1;
            mark_addr            = grant_group;
            mark_data            = 1'b1;
            live_nxt             = live_r + CNT_W'(1);
            out_nxt.granted_slot = {grant_group, OFS_W'(0)};
          end
        end
        KIND_RELEASE: begin
          if (!aligned || !live_hit || (stk_stat.depth >= CNT_W'(MAX_GROUPS)) ||
              (live_r == '0)) begin
            out_nxt.status = ST_BAD;
          end else begin
            stk_cmd.push       = 1'b1;
            stk_cmd.push_group = req_group;
            mark_we            = 1'b1;
            mark_data          = 1'b0;
            live_nxt           = live_r - CNT_W'(1);
          end
        end
        KIND_REWIND: begin
          stk_cmd.clear = 1'b1;
          bump_nxt      = '0;
          live_nxt      = '0;
        end
        KIND_CLEAR: begin
          stk_cmd.clear = 1'b1;
          bump_nxt      = '0;
          live_nxt      = '0;
          peak_nxt      = '0;
        end
        KIND_QUERY: begin
          out_nxt.slot_live = live_hit;
        end
        default: begin
        end
      endcase

      out_nxt.live_groups = live_nxt;
      out_nxt.peak_groups = peak_nxt;
    end
  end

  always_comb begin
    req_v_nxt = req_v_r;
    if (accept) begin
      req_v_nxt = 1'b1;
    end else if (advance) begin
      req_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  gsa_free_stack u_stack (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd_i  (stk_cmd),
    .stat_o (stk_stat)
  );

  // Mark memory: written by the request in flight, read when a request
  // transfers in.
  always_ff @(posedge clk) begin
    if (mark_we) begin
      marks[mark_addr] <= mark_data;
    end
    if (accept) begin
      mark_rd_r <= marks[in_data.slot_index[SLOT_W-1:OFS_W]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= in_data;
      fwd_addr_r <= mark_addr;
      fwd_data_r <= mark_data;
    end
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
      out_v_r <= 1'b0;
      fwd_v_r <= 1'b0;
      bump_r  <= '0;
      peak_r  <= '0;
      live_r  <= '0;
    end else begin
      req_v_r <= req_v_nxt;
      out_v_r <= out_v_nxt;
      if (accept) begin
        fwd_v_r <= mark_we;
      end
      bump_r <= bump_nxt;
      peak_r <= peak_nxt;
      live_r <= live_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

@@ rtl/gsa_checker.sv @@
// ----------------------------------------------------------------------------
// gsa_checker
// Port-level checks of the group slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module gsa_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input gsa_pkg::gsa_out_t out_data
);
  import gsa_pkg::*;

  // A held result must not change or vanish.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Granted slots are always the first slot of a group.
  a_grant_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.granted_slot[OFS_W-1:0] == '0)
    else $error("granted slot not group aligned");

  // Failed requests grant nothing and answer no query.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.granted_slot == '0 && !out_data.slot_live)
    else $error("failed request carries a grant or live answer");

  // Live groups all came from the bump pointer, so never exceed the peak.
  a_live_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.live_groups <= out_data.peak_groups)
    else $error("live count above peak");

endmodule

bind group_slot_allocator gsa_checker u_gsa_checker (.*);

@@ bench/group_slot_allocator_test.sv @@
// ----------------------------------------------------------------------------
// group_slot_allocator_test
// Self-checking bench for the group slot allocator. Requests are driven
// through the valid/stall input channel and predicted in order by a small
// scoreboard that keeps its own free stack, bump pointer, counters and live
// marks. Each result transfer is compared field by field with the oldest
// prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module group_slot_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gsa_pkg::*;

  // The limit lies far beyond the length of a run with the longest gaps and
  // stalls, so it only trips on a hang.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 450;
  // The block has a two-stage pipeline; the extra wait after the last result
  // catches any stray transfer.
  localparam int DRAIN_CYCLES = 10;
  localparam int SLOT_MAX     = (1 << SLOT_W) - 1;

  // Scoreboard: mirrors the allocator state and queues the reply that each
  // accepted request should produce.
  class slot_pool_checker;
    bit [GRP_W-1:0] free_groups [MAX_GROUPS];
    bit [CNT_W-1:0] free_count;
    bit [CNT_W-1:0] next_fresh;
    bit [CNT_W-1:0] high_water;
    bit [CNT_W-1:0] live_total;
    bit             live_flag [MAX_GROUPS];
    gsa_out_t       expected_replies [$];
    int             failures;

    function new();
      forget_groups();
      high_water = '0;
      failures   = 0;
    endfunction

    // Rewind: the stack, bump pointer, count and every live mark go back
    // to empty.
    function void forget_groups();
      free_count = '0;
      next_fresh = '0;
      live_total = '0;
      foreach (live_flag[i]) live_flag[i] = 1'b0;
    endfunction

    function bit group_is_live(int g);
      return g < int'(next_fresh) && g < MAX_GROUPS && live_flag[g];
    endfunction

    function void note_request(gsa_in_t req);
      gsa_out_t reply;
      int       slot;
      int       g;
      reply = '0;
      slot  = int'(req.slot_index);
      g     = -1;
      case (req.kind)
        KIND_ALLOC: begin
          if (free_count != 0) begin
            free_count--;
            g = int'(free_groups[free_count]);
          end else if (next_fresh < MAX_GROUPS) begin
            g = int'(next_fresh);
            next_fresh++;
            if (next_fresh > high_water) high_water = next_fresh;
          end else begin
            reply.status = ST_FULL;
          end
          if (g >= 0) begin
            live_flag[g] = 1'b1;
            live_total++;
            reply.granted_slot = SLOT_W'(g * GROUP_SLOTS);
          end
        end
        KIND_RELEASE: begin
          g = slot / GROUP_SLOTS;
          if (slot % GROUP_SLOTS != 0 || !group_is_live(g) ||
              free_count >= MAX_GROUPS || live_total == 0) begin
            reply.status = ST_BAD;
          end else begin
            free_groups[free_count] = GRP_W'(g);
            free_count++;
            live_flag[g] = 1'b0;
            live_total--;
          end
        end
        KIND_REWIND: begin
          forget_groups();
        end
        KIND_CLEAR: begin
          forget_groups();
          high_water = '0;
        end
        KIND_QUERY: begin
          reply.slot_live = group_is_live(slot / GROUP_SLOTS);
        end
        default: ;
      endcase
      reply.live_groups = live_total;
      reply.peak_groups = high_water;
      expected_replies = {expected_replies, reply};
    endfunction

    function void compare_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(gsa_out_t got);
      gsa_out_t want;
      if (expected_replies.size() == 0) begin
        failures++;
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      want = expected_replies.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("granted_slot", want.granted_slot, got.granted_slot);
      compare_field("slot_live", want.slot_live, got.slot_live);
      compare_field("live_groups", want.live_groups, got.live_groups);
      compare_field("peak_groups", want.peak_groups, got.peak_groups);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  gsa_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  gsa_out_t out_data;

  slot_pool_checker chk = new();
  int unsigned      cycle_count = 0;
  // When set, the sender runs back to back with no gaps between transfers.
  bit               no_gaps = 1'b0;

  group_slot_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result monitor. Values read here are the ones present before this edge,
  // so a transfer is seen exactly when the block sees it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) chk.check_result(out_data);
  end

  // Receiver back-pressure: calm stretches with no stall, busy stretches
  // with random stalls, and now and then a long solid stall.
  initial begin
    int mode;
    int len;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      mode = $urandom_range(0, 9);
      len  = (mode == 0) ? $urandom_range(8, 24) : $urandom_range(10, 120);
      repeat (len) begin
        if (mode == 0) out_stall <= 1'b1;
        else if (mode <= 3) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 99) < 40);
        @(posedge clk);
      end
    end
  end

  function automatic gsa_in_t make_request(kind_t k, int slot);
    gsa_in_t r;
    r.kind       = k;
    r.slot_index = slot[SLOT_W-1:0];
    return r;
  endfunction

  // Gap before the next request: mostly none or short, a few long ones.
  function automatic int sender_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 16);
  endfunction

  // Any live group, found from a random starting point; -1 if none is live.
  function automatic int pick_live_group();
    int start;
    int g;
    start = $urandom_range(0, MAX_GROUPS - 1);
    for (int i = 0; i < MAX_GROUPS; i++) begin
      g = (start + i) % MAX_GROUPS;
      if (chk.group_is_live(g)) return g;
    end
    return -1;
  endfunction

  // Random request, weighted toward well-formed traffic: allocations,
  // releases and queries of groups that are actually live. The rest are
  // misaligned, out-of-range and double releases, stray queries, unused
  // kinds, and occasional rewinds and clears.
  function automatic gsa_in_t random_request();
    int p;
    int g;
    int slot;
    p    = $urandom_range(0, 99);
    slot = $urandom_range(0, SLOT_MAX);
    g    = pick_live_group();
    if (p < 45) return make_request(KIND_ALLOC, slot);
    if (p < 68 && g >= 0) return make_request(KIND_RELEASE, g * GROUP_SLOTS);
    if (p < 72 && g >= 0)
      return make_request(KIND_RELEASE, g * GROUP_SLOTS + $urandom_range(1, GROUP_SLOTS - 1));
    if (p < 76) return make_request(KIND_RELEASE, slot);
    // The group on top of the free stack was just released, so this is a
    // double release.
    if (p < 80 && chk.free_count != 0)
      return make_request(KIND_RELEASE,
                          int'(chk.free_groups[chk.free_count - 1]) * GROUP_SLOTS);
    if (p < 90 && g >= 0)
      return make_request(KIND_QUERY, g * GROUP_SLOTS + $urandom_range(0, GROUP_SLOTS - 1));
    if (p < 95) return make_request(KIND_QUERY, slot);
    if (p < 97) return make_request(kind_t'($urandom_range(5, 7)), slot);
    if (p < 99) return make_request(KIND_REWIND, slot);
    return make_request(KIND_CLEAR, slot);
  endfunction

  // Present one request and hold it until the block takes it. The stall
  // read after the edge is the value the block used at that edge.
  task automatic send(gsa_in_t req);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    chk.note_request(req);
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has transferred.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk.expected_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    gsa_in_t plan [$];
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: queries and releases on an empty pool, the first
    // allocations, a misaligned release, a good release followed by a
    // double release, reuse from the free stack, aligned and misaligned
    // releases of the top slot above the bump pointer, the unused kinds,
    // then rewind (marks gone, peak kept) and clear (peak gone too).
    plan = {plan, make_request(KIND_QUERY, 0)};
    plan = {plan, make_request(KIND_RELEASE, 0)};
    plan = {plan, make_request(KIND_ALLOC, SLOT_MAX)};
    plan = {plan, make_request(KIND_ALLOC, 0)};
    plan = {plan, make_request(KIND_ALLOC, 0)};
    plan = {plan, make_request(KIND_QUERY, 2 * GROUP_SLOTS - 1)};
    plan = {plan, make_request(KIND_RELEASE, GROUP_SLOTS + 1)};
    plan = {plan, make_request(KIND_RELEASE, GROUP_SLOTS)};
    plan = {plan, make_request(KIND_RELEASE, GROUP_SLOTS)};
    plan = {plan, make_request(KIND_QUERY, GROUP_SLOTS)};
    plan = {plan, make_request(KIND_ALLOC, 0)};
    plan = {plan, make_request(KIND_RELEASE, SLOT_MAX)};
    plan = {plan, make_request(KIND_RELEASE, SLOT_MAX + 1 - GROUP_SLOTS)};
    plan = {plan, make_request(KIND_QUERY, SLOT_MAX)};
    plan = {plan, make_request(kind_t'(3'd5), SLOT_MAX)};
    plan = {plan, make_request(kind_t'(3'd6), 0)};
    plan = {plan, make_request(kind_t'(3'd7), 0)};
    plan = {plan, make_request(KIND_REWIND, 0)};
    plan = {plan, make_request(KIND_QUERY, 0)};
    plan = {plan, make_request(KIND_RELEASE, 0)};
    plan = {plan, make_request(KIND_ALLOC, 0)};
    plan = {plan, make_request(KIND_CLEAR, SLOT_MAX)};
    plan = {plan, make_request(KIND_ALLOC, 0)};
    foreach (plan[i]) send(plan[i]);

    // Hold the sender off until the pipeline is completely empty.
    drain_results();

    // Exhaust the pool: allocate until the bump pointer reaches the end and
    // the free stack is empty, then show that further allocations report
    // out of space and that a released group is handed back out.
    no_gaps = 1'b1;
    while (!(chk.next_fresh == MAX_GROUPS && chk.free_count == 0))
      send(make_request(KIND_ALLOC, $urandom_range(0, SLOT_MAX)));
    no_gaps = 1'b0;
    send(make_request(KIND_ALLOC, 0));
    send(make_request(KIND_ALLOC, SLOT_MAX));
    send(make_request(KIND_QUERY, SLOT_MAX));
    send(make_request(KIND_RELEASE, SLOT_MAX + 1 - GROUP_SLOTS));
    send(make_request(KIND_QUERY, SLOT_MAX));
    send(make_request(KIND_ALLOC, 0));
    send(make_request(KIND_ALLOC, 0));

    // Random traffic, switching now and then into back-to-back stretches.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      send(random_request());
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
